/* rtl/hrbd_pkg.sv */
`timescale 1ns / 1ps
package hrbd_pkg;
  typedef struct packed {
    logic       func;
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic       body_valid;
    logic [7:0] body_byte;
    logic [1:0] phase;
    logic [2:0] error_code;
    logic       body_last;
  } out_item_t;

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_BODY   = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;
  localparam logic [1:0] PH_ERROR  = 2'd3;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_NO_HTTP  = 3'd1;
  localparam logic [2:0] ERR_NO_SPACE = 3'd2;
  localparam logic [2:0] ERR_NOT_200  = 3'd3;
  localparam logic [2:0] ERR_NO_LEN   = 3'd4;
  localparam logic [2:0] ERR_LEN_OVER = 3'd5;
  localparam logic [2:0] ERR_FRAMING  = 3'd6;
  localparam logic [2:0] ERR_TOO_LONG = 3'd7;

  localparam logic [2:0] CS_CR   = 3'd0;
  localparam logic [2:0] CS_LF   = 3'd1;
  localparam logic [2:0] CS_HEX  = 3'd2;
  localparam logic [2:0] CS_EXT  = 3'd3;
  localparam logic [2:0] CS_ELF  = 3'd4;
  localparam logic [2:0] CS_DATA = 3'd5;

  function automatic logic [7:0] len_char(input logic [3:0] i);
    logic [7:0] c;
    unique case (i)
      4'd0: c = "c";  4'd1: c = "o";  4'd2: c = "n";  4'd3: c = "t";
      4'd4: c = "e";  4'd5: c = "n";  4'd6: c = "t";  4'd7: c = "-";
      4'd8: c = "l";  4'd9: c = "e";  4'd10: c = "n"; 4'd11: c = "g";
      4'd12: c = "t"; 4'd13: c = "h"; 4'd14: c = ":";
      default: c = 8'd0;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] chk_char(input logic [4:0] i);
    logic [7:0] c;
    unique case (i)
      5'd0: c = "t";  5'd1: c = "r";  5'd2: c = "a";  5'd3: c = "n";
      5'd4: c = "s";  5'd5: c = "f";  5'd6: c = "e";  5'd7: c = "r";
      5'd8: c = "-";  5'd9: c = "e";  5'd10: c = "n"; 5'd11: c = "c";
      5'd12: c = "o"; 5'd13: c = "d"; 5'd14: c = "i"; 5'd15: c = "n";
      5'd16: c = "g"; 5'd17: c = ":"; 5'd18: c = " "; 5'd19: c = "c";
      5'd20: c = "h"; 5'd21: c = "u"; 5'd22: c = "n"; 5'd23: c = "k";
      5'd24: c = "e"; 5'd25: c = "d";
      default: c = 8'd0;
    endcase
    return c;
  endfunction
endpackage

/* rtl/hrbd_fifo.sv */
`timescale 1ns / 1ps
module hrbd_fifo #(
  parameter int W = 9
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         rd,
  output logic [W-1:0] rdata,
  output logic         empty
);
  logic [W-1:0] mem [2];
  logic         wptr;
  logic         rptr;
  logic [1:0]   count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr && !full) mem[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr && !full) wptr <= ~wptr;
      if (rd && !empty) rptr <= ~rptr;
      count <= count + 2'(wr && !full) - 2'(rd && !empty);
    end
  end
endmodule

/* rtl/hrbd_front.sv */
`timescale 1ns / 1ps
module hrbd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  hrbd_pkg::in_item_t in_item,
  output logic              full,
  input  logic              q_full,
  output logic              q_wr,
  output logic [8:0]        q_data
);
  import hrbd_pkg::*;

  // classification: start flag and raw byte, passed through a registered stage
  logic       vld;
  logic [8:0] data;

  assign full   = vld && q_full;
  assign q_wr   = vld;
  assign q_data = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (!full) begin
      vld <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) data <= {in_item.func, in_item.in_byte};
  end
endmodule

/* rtl/hrbd_back.sv */
`timescale 1ns / 1ps
module hrbd_back #(
  parameter int MAX_SIZE_LINE  = 32,
  parameter int MAX_HEX_DIGITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  logic [8:0]         q_data,
  output logic               q_rd,
  output hrbd_pkg::out_item_t res,
  output logic               empty,
  input  logic               pop
);
  import hrbd_pkg::*;

  localparam int SLW = $clog2(MAX_SIZE_LINE + 1);

  logic [1:0]     phase_reg, phase_next;
  logic [2:0]     error_reg, error_next;
  logic           chunked_mode, chunked_mode_next;
  logic [3:0]     status_line_pos, status_line_pos_next;
  logic [3:0]     length_match_pos, length_match_pos_next;
  logic [4:0]     chunked_match_pos, chunked_match_pos_next;
  logic [1:0]     header_end_pos, header_end_pos_next;
  logic [3:0]     length_flags, length_flags_next;
  logic [31:0]    length_value, length_value_next;
  logic [31:0]    remaining_count, remaining_count_next;
  logic [2:0]     chunk_step, chunk_step_next;
  logic [SLW-1:0] size_line_count, size_line_count_next;
  logic [3:0]     hex_digit_count, hex_digit_count_next;

  logic       out_vld;
  out_item_t  out_reg, out_next;
  logic       take;
  logic [7:0] b, lc;
  logic       st;
  logic [4:0] cp;
  logic [3:0] lp;
  logic [35:0] prod;
  logic [4:0] hv;
  logic       valid, last, done, fail, hdr_end;
  logic [2:0] fail_code;
  logic [31:0] rc_dec;

  assign empty = !out_vld;
  assign res   = out_reg;
  assign take  = !q_empty && (!out_vld || pop);
  assign q_rd  = take;
  assign st    = q_data[8];
  assign b     = q_data[7:0];
  assign lc    = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
  assign prod  = {length_value, 3'b000} + {2'b00, length_value, 1'b0} + 36'(b - "0");
  assign rc_dec = (remaining_count != 32'd0) ? remaining_count - 32'd1 : 32'd0;

  always_comb begin
    if (b >= "0" && b <= "9") hv = {1'b0, 4'(b - "0")};
    else if (b >= "a" && b <= "f") hv = {1'b0, 4'(b - "a" + 8'd10)};
    else if (b >= "A" && b <= "F") hv = {1'b0, 4'(b - "A" + 8'd10)};
    else hv = 5'h10;
  end

  always_comb begin
    phase_next = phase_reg; error_next = error_reg;
    chunked_mode_next = chunked_mode; status_line_pos_next = status_line_pos;
    length_match_pos_next = length_match_pos; chunked_match_pos_next = chunked_match_pos;
    header_end_pos_next = header_end_pos; length_flags_next = length_flags;
    length_value_next = length_value; remaining_count_next = remaining_count;
    chunk_step_next = chunk_step; size_line_count_next = size_line_count;
    hex_digit_count_next = hex_digit_count;
    valid = 1'b0; last = 1'b0; done = 1'b0; fail = 1'b0; fail_code = ERR_NONE;
    hdr_end = 1'b0; cp = 5'd0; lp = 4'd0;
    if (st) begin
      phase_next = PH_HEADER; error_next = ERR_NONE; chunked_mode_next = 1'b0;
      status_line_pos_next = 4'd0; length_match_pos_next = 4'd0;
      chunked_match_pos_next = 5'd0; header_end_pos_next = 2'd0;
      length_flags_next = 4'd0; length_value_next = 32'd0; remaining_count_next = 32'd0;
      chunk_step_next = CS_CR; size_line_count_next = '0; hex_digit_count_next = 4'd0;
    end else if (phase_reg == PH_HEADER) begin
      if (status_line_pos <= 4'd3) begin
        priority case (status_line_pos)
          4'd0: status_line_pos_next = (b == "H") ? 4'd1 : 4'd9;
          4'd1: status_line_pos_next = (b == "T") ? 4'd2 : 4'd9;
          4'd2: status_line_pos_next = (b == "T") ? 4'd3 : 4'd9;
          default: status_line_pos_next = (b == "P") ? 4'd4 : 4'd9;
        endcase
      end else if (status_line_pos == 4'd4) begin
        if (b == " ") status_line_pos_next = 4'd5;
      end else if (status_line_pos <= 4'd7) begin
        if (status_line_pos == 4'd5)
          status_line_pos_next = (b == "2") ? 4'd6 : 4'd10;
        else
          status_line_pos_next = (b == "0") ? status_line_pos + 4'd1 : 4'd10;
      end
      if (!length_flags[3]) begin
        cp = (chunked_match_pos > 5'd25) ? 5'd0 : chunked_match_pos;
        if (cp == 5'd18 && lc == "c") cp = 5'd20;
        else if (lc == chk_char(cp)) cp = cp + 5'd1;
        else cp = (lc == "t") ? 5'd1 : 5'd0;
        if (cp == 5'd26) begin
          length_flags_next[3] = 1'b1;
          cp = 5'd0;
        end
        chunked_match_pos_next = cp;
      end
      if (!length_flags[0]) begin
        lp = (length_match_pos > 4'd14) ? 4'd0 : length_match_pos;
        if (lc == len_char(lp)) lp = lp + 4'd1;
        else lp = (lc == "c") ? 4'd1 : 4'd0;
        if (lp == 4'd15) begin
          length_flags_next[0] = 1'b1;
          length_flags_next[1] = 1'b1;
        end
        length_match_pos_next = lp;
      end else if (length_flags[1]) begin
        length_match_pos_next = 4'd0;
        if (length_match_pos == 4'd15 && b == " ") begin
        end else if (b >= "0" && b <= "9") begin
          if (prod[35:32] != 4'd0) begin
            length_flags_next[2] = 1'b1;
            length_value_next = 32'hFFFF_FFFF;
          end else begin
            length_value_next = prod[31:0];
          end
        end else begin
          length_flags_next[1] = 1'b0;
        end
      end
      if (b == 8'h0D) begin
        header_end_pos_next = (header_end_pos == 2'd2) ? 2'd3 : 2'd1;
      end else if (b == 8'h0A) begin
        if (header_end_pos == 2'd3) begin
          header_end_pos_next = 2'd0;
          hdr_end = 1'b1;
        end else begin
          header_end_pos_next = (header_end_pos == 2'd1) ? 2'd2 : 2'd0;
        end
      end else begin
        header_end_pos_next = 2'd0;
      end
      // header judgement uses flags as updated by this byte
      if (hdr_end) begin
        if (status_line_pos <= 4'd3 || status_line_pos == 4'd9) begin
          fail = 1'b1; fail_code = ERR_NO_HTTP;
        end else if (status_line_pos == 4'd4) begin
          fail = 1'b1; fail_code = ERR_NO_SPACE;
        end else if (status_line_pos != 4'd8) begin
          fail = 1'b1; fail_code = ERR_NOT_200;
        end else if (length_flags_next[0]) begin
          if (length_flags_next[2]) begin
            fail = 1'b1; fail_code = ERR_LEN_OVER;
          end else begin
            remaining_count_next = length_value_next;
            if (length_value_next == 32'd0) begin
              phase_next = PH_DONE; last = 1'b1;
            end else begin
              phase_next = PH_BODY;
            end
          end
        end else if (length_flags_next[3]) begin
          phase_next = PH_BODY; chunked_mode_next = 1'b1; chunk_step_next = CS_HEX;
          size_line_count_next = SLW'(2); hex_digit_count_next = 4'd0;
          remaining_count_next = 32'd0;
        end else begin
          fail = 1'b1; fail_code = ERR_NO_LEN;
        end
      end
    end else if (phase_reg == PH_BODY) begin
      if (!chunked_mode) begin
        valid = 1'b1;
        remaining_count_next = rc_dec;
        if (rc_dec == 32'd0) begin
          phase_next = PH_DONE; last = 1'b1;
        end
      end else if (chunk_step == CS_DATA) begin
        valid = 1'b1;
        remaining_count_next = rc_dec;
        if (rc_dec == 32'd0) begin
          chunk_step_next = CS_CR; size_line_count_next = '0; hex_digit_count_next = 4'd0;
        end
      end else begin
        // saturate: count only matters up to the limit
        size_line_count_next = (size_line_count >= SLW'(MAX_SIZE_LINE)) ?
                               size_line_count : size_line_count + SLW'(1);
        unique case (chunk_step)
          CS_CR: if (b == 8'h0D) chunk_step_next = CS_LF;
                 else begin fail = 1'b1; fail_code = ERR_FRAMING; end
          CS_LF: if (b == 8'h0A) chunk_step_next = CS_HEX;
                 else begin fail = 1'b1; fail_code = ERR_FRAMING; end
          CS_HEX: begin
            if (!hv[4]) begin
              hex_digit_count_next = hex_digit_count + 4'd1;
              if (hex_digit_count_next > 4'(MAX_HEX_DIGITS)) begin
                fail = 1'b1; fail_code = ERR_TOO_LONG;
              end else begin
                remaining_count_next = {remaining_count[27:0], hv[3:0]};
              end
            end else begin
              chunk_step_next = (b == 8'h0D) ? CS_ELF : CS_EXT;
            end
          end
          CS_EXT: if (b == 8'h0D) chunk_step_next = CS_ELF;
          CS_ELF: begin
            if (b == 8'h0A) done = 1'b1;
            else if (b != 8'h0D) chunk_step_next = CS_EXT;
          end
          default: begin fail = 1'b1; fail_code = ERR_FRAMING; end
        endcase
        if (!fail) begin
          if (done) begin
            if (remaining_count_next == 32'd0) begin
              phase_next = PH_DONE; last = 1'b1;
            end else begin
              chunk_step_next = CS_DATA;
            end
          end else if (size_line_count_next >= SLW'(MAX_SIZE_LINE)) begin
            fail = 1'b1; fail_code = ERR_TOO_LONG;
          end
        end
      end
    end
    if (fail) begin
      phase_next = PH_ERROR; error_next = fail_code;
    end
    out_next.body_valid = valid;
    out_next.body_byte  = valid ? b : 8'd0;
    out_next.phase      = phase_next;
    out_next.error_code = error_next;
    out_next.body_last  = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
      phase_reg <= PH_HEADER; error_reg <= ERR_NONE; chunked_mode <= 1'b0;
      status_line_pos <= 4'd0; length_match_pos <= 4'd0; chunked_match_pos <= 5'd0;
      header_end_pos <= 2'd0; length_flags <= 4'd0; length_value <= 32'd0;
      remaining_count <= 32'd0; chunk_step <= CS_CR; size_line_count <= '0;
      hex_digit_count <= 4'd0;
    end else begin
      if (take) out_vld <= 1'b1;
      else if (pop) out_vld <= 1'b0;
      if (take) begin
        phase_reg <= phase_next; error_reg <= error_next;
        chunked_mode <= chunked_mode_next; status_line_pos <= status_line_pos_next;
        length_match_pos <= length_match_pos_next;
        chunked_match_pos <= chunked_match_pos_next;
        header_end_pos <= header_end_pos_next; length_flags <= length_flags_next;
        length_value <= length_value_next; remaining_count <= remaining_count_next;
        chunk_step <= chunk_step_next; size_line_count <= size_line_count_next;
        hex_digit_count <= hex_digit_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) out_reg <= out_next;
  end
endmodule

/* rtl/http_response_body_deframer_top.sv */
`timescale 1ns / 1ps
// Takes an HTTP response one byte per request and gives one result per request: a body
// byte when there is one, plus phase, error code and an end-of-body mark. Sustains one
// request per cycle while results are popped; otherwise full stalls new requests. Each
// request passes through the input register in the front part, an entry of the two-entry
// queue, and the registered parser state and result in the back part.
module http_response_body_deframer_top #(
  parameter int MAX_SIZE_LINE  = 32,
  parameter int MAX_HEX_DIGITS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  hrbd_pkg::in_item_t  in_item,
  output logic                empty,
  input  logic                pop,
  output hrbd_pkg::out_item_t out_item
);
  import hrbd_pkg::*;

  logic       q_wr, q_full, q_rd, q_empty;
  logic [8:0] q_wdata, q_rdata;

  hrbd_front u_front (
    .clk(clk), .rst(rst), .push(push), .in_item(in_item), .full(full),
    .q_full(q_full), .q_wr(q_wr), .q_data(q_wdata)
  );

  hrbd_fifo #(.W(9)) u_fifo (
    .clk(clk), .rst(rst), .wr(q_wr), .wdata(q_wdata), .full(q_full),
    .rd(q_rd), .rdata(q_rdata), .empty(q_empty)
  );

  hrbd_back #(.MAX_SIZE_LINE(MAX_SIZE_LINE), .MAX_HEX_DIGITS(MAX_HEX_DIGITS)) u_back (
    .clk(clk), .rst(rst), .q_empty(q_empty), .q_data(q_rdata), .q_rd(q_rd),
    .res(out_item), .empty(empty), .pop(pop)
  );
endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  import hrbd_pkg::*;

  logic      clk;
  logic      rst;
  logic      push;
  logic      full;
  in_item_t  in_item;
  logic      empty;
  logic      pop;
  out_item_t out_item;

  http_response_body_deframer_top dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item)
  );

  localparam int SIZE_LINE_MAX = 32;
  localparam int HEX_DIGITS_MAX = 8;
  localparam int LIMIT_CYCLES = 400000;

  // parser copy
  logic [1:0]  p_phase;
  logic [2:0]  p_err;
  logic        p_chunked;
  logic [3:0]  p_status;
  logic [3:0]  p_lenpos;
  logic [4:0]  p_chkpos;
  logic [1:0]  p_endpos;
  logic        f_found, f_parsing, f_over, f_chk;
  logic [31:0] p_lenval;
  logic [31:0] p_remain;
  logic [2:0]  p_cstep;
  logic [31:0] p_linecnt;
  logic [3:0]  p_hexcnt;

  out_item_t expected_q[$];
  int        mismatches;
  int        cycles;
  int        items_sent;
  int        send_idle_pct;
  int        recv_idle_pct;
  bit        hold_off;

  function automatic logic [7:0] to_lower(logic [7:0] b);
    return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
  endfunction

  function automatic logic [7:0] len_pattern(int i);
    string s;
    s = "content-length:";
    return s[i];
  endfunction

  function automatic logic [7:0] chunked_pattern(int i);
    string s;
    s = "transfer-encoding: chunked";
    return s[i];
  endfunction

  function automatic int hex_value(logic [7:0] b);
    if (b >= "0" && b <= "9") return b - "0";
    if (b >= "a" && b <= "f") return b - "a" + 10;
    if (b >= "A" && b <= "F") return b - "A" + 10;
    return -1;
  endfunction

  task automatic clear_parser();
    p_phase = PH_HEADER; p_err = ERR_NONE; p_chunked = 0; p_status = 0;
    p_lenpos = 0; p_chkpos = 0; p_endpos = 0;
    f_found = 0; f_parsing = 0; f_over = 0; f_chk = 0;
    p_lenval = 0; p_remain = 0; p_cstep = CS_CR; p_linecnt = 0; p_hexcnt = 0;
  endtask

  task automatic set_error(logic [2:0] code);
    p_phase = PH_ERROR;
    p_err = code;
  endtask

  task automatic judge_header(inout logic last);
    if (p_status <= 3 || p_status == 9) set_error(ERR_NO_HTTP);
    else if (p_status == 4) set_error(ERR_NO_SPACE);
    else if (p_status != 8) set_error(ERR_NOT_200);
    else if (f_found) begin
      if (f_over) set_error(ERR_LEN_OVER);
      else begin
        p_remain = p_lenval;
        if (p_remain == 0) begin
          p_phase = PH_DONE; last = 1;
        end else p_phase = PH_BODY;
      end
    end else if (f_chk) begin
      p_phase = PH_BODY; p_chunked = 1; p_cstep = CS_HEX;
      p_linecnt = 2; p_hexcnt = 0; p_remain = 0;
    end else set_error(ERR_NO_LEN);
  endtask

  task automatic header_step(logic [7:0] b, inout logic last);
    logic [7:0] lc;
    logic [4:0] cp;
    logic [3:0] lp;
    logic [63:0] v;
    string      okstr;
    string      httpstr;
    lc = to_lower(b);
    okstr = "200";
    httpstr = "HTTP";
    if (p_status <= 3) p_status = (b == httpstr[p_status]) ? p_status + 1 : 9;
    else if (p_status == 4) begin
      if (b == " ") p_status = 5;
    end else if (p_status <= 7) p_status = (b == okstr[p_status - 5]) ? p_status + 1 : 10;

    if (!f_chk) begin
      cp = p_chkpos;
      if (cp > 25) cp = 0;
      if (cp == 18 && lc == "c") cp = 20;
      else if (lc == chunked_pattern(cp)) cp = cp + 1;
      else cp = (lc == "t") ? 1 : 0;
      if (cp == 26) begin
        f_chk = 1; cp = 0;
      end
      p_chkpos = cp;
    end

    if (!f_found) begin
      lp = p_lenpos;
      if (lp > 14) lp = 0;
      if (lc == len_pattern(lp)) lp = lp + 1;
      else lp = (lc == "c") ? 1 : 0;
      if (lp == 15) begin
        f_found = 1; f_parsing = 1;
      end
      p_lenpos = lp;
    end else if (f_parsing) begin
      if (p_lenpos == 15 && b == " ") p_lenpos = 0;
      else if (b >= "0" && b <= "9") begin
        v = 64'(p_lenval) * 10 + 64'(b - "0");
        if (v > 64'hFFFF_FFFF) begin
          f_over = 1; v = 64'hFFFF_FFFF;
        end
        p_lenval = v[31:0];
        p_lenpos = 0;
      end else begin
        f_parsing = 0; p_lenpos = 0;
      end
    end

    if (b == 8'h0d) p_endpos = (p_endpos == 2) ? 3 : 1;
    else if (b == 8'h0a) begin
      if (p_endpos == 3) begin
        p_endpos = 0;
        judge_header(last);
      end else p_endpos = (p_endpos == 1) ? 2 : 0;
    end else p_endpos = 0;
  endtask

  task automatic chunk_step(logic [7:0] b, inout logic valid, inout logic last);
    logic done;
    int   h;
    done = 0;
    if (p_cstep == CS_DATA) begin
      valid = 1;
      if (p_remain != 0) p_remain--;
      if (p_remain == 0) begin
        p_cstep = CS_CR; p_linecnt = 0; p_hexcnt = 0;
      end
      return;
    end
    p_linecnt++;
    case (p_cstep)
      CS_CR: if (b == 8'h0d) p_cstep = CS_LF; else set_error(ERR_FRAMING);
      CS_LF: if (b == 8'h0a) p_cstep = CS_HEX; else set_error(ERR_FRAMING);
      CS_HEX: begin
        h = hex_value(b);
        if (h >= 0) begin
          p_hexcnt++;
          if (p_hexcnt > HEX_DIGITS_MAX) set_error(ERR_TOO_LONG);
          else p_remain = {p_remain[27:0], 4'(h)};
        end else p_cstep = (b == 8'h0d) ? CS_ELF : CS_EXT;
      end
      CS_EXT: if (b == 8'h0d) p_cstep = CS_ELF;
      CS_ELF: begin
        if (b == 8'h0a) done = 1;
        else if (b != 8'h0d) p_cstep = CS_EXT;
      end
      default: set_error(ERR_FRAMING);
    endcase
    if (p_phase != PH_BODY) return;
    if (done) begin
      if (p_remain == 0) begin
        p_phase = PH_DONE; last = 1;
      end else p_cstep = CS_DATA;
    end else if (p_linecnt >= SIZE_LINE_MAX) set_error(ERR_TOO_LONG);
  endtask

  task automatic predict_body_result(input in_item_t it, output out_item_t r);
    logic valid, last;
    valid = 0; last = 0;
    if (it.func) clear_parser();
    else if (p_phase == PH_HEADER) header_step(it.in_byte, last);
    else if (p_phase == PH_BODY) begin
      if (p_chunked) chunk_step(it.in_byte, valid, last);
      else begin
        valid = 1;
        if (p_remain != 0) p_remain--;
        if (p_remain == 0) begin
          p_phase = PH_DONE; last = 1;
        end
      end
    end
    r.body_valid = valid;
    r.body_byte = valid ? it.in_byte : 8'd0;
    r.phase = p_phase;
    r.error_code = p_err;
    r.body_last = last;
  endtask

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    mismatches++;
  endtask

  task automatic send_request(logic f, logic [7:0] b);
    in_item_t  it;
    out_item_t r;
    it.func = f;
    it.in_byte = b;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 0;
      @(posedge clk);
    end
    push <= 1;
    in_item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_body_result(it, r);
    expected_q.push_back(r);
    items_sent++;
  endtask

  task automatic send_string(string s);
    for (int i = 0; i < s.len(); i++) send_request(0, s[i]);
  endtask

  task automatic start_response();
    send_request(1, $urandom_range(255));
  endtask

  task automatic send_random_bytes(int n);
    for (int i = 0; i < n; i++) send_request(0, $urandom_range(255));
  endtask

  // checker
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && pop && !empty) begin
      if (expected_q.size() == 0) report("unexpected result", int'(out_item), 0);
      else begin
        out_item_t e;
        e = expected_q.pop_front();
        if (out_item.body_valid !== e.body_valid) report("body_valid", out_item.body_valid, e.body_valid);
        if (out_item.body_byte !== e.body_byte) report("body_byte", out_item.body_byte, e.body_byte);
        if (out_item.phase !== e.phase) report("phase", out_item.phase, e.phase);
        if (out_item.error_code !== e.error_code)
          report("error_code", out_item.error_code, e.error_code);
        if (out_item.body_last !== e.body_last) report("body_last", out_item.body_last, e.body_last);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || hold_off) pop <= 0;
    else pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    wait (cycles >= LIMIT_CYCLES);
    $display("testbench: FAIL");
    $finish;
  end

  task automatic test_length_body();
    start_response();
    send_string("HTTP/1.1 200 OK\r\ncontent-LENGTH: 5\r\n\r\n");
    send_string("ab");
    send_request(0, 8'h00);
    send_string("\377cXY");
    start_response();
    send_string("HTTP/1.1 200 OK\r\nContent-Length:\r\n\r\nz");
  endtask

  task automatic test_header_errors();
    start_response();
    send_string("HTTX 200\r\n\r\n");
    start_response();
    send_string("HTTP\r\n\r\n");
    start_response();
    send_string("HTTP 404\r\n\r\n");
    start_response();
    send_string("HTTP 200\r\n\r\n");
    start_response();
    send_string("HTTP 200\r\nContent-Length: 4294967296\r\n\r\n");
    start_response();
    send_string("HTTP 200\r\nContent-Length: 0004294967295\r\n\r\nq");
  endtask

  task automatic test_chunked();
    start_response();
    send_string("HTTP/1.1 200 OK\r\nTRANSFER-ENCODING:chunked\r\n\r\n");
    send_string("3;ext=1\r\nabc\r\nA\r\n0123456789\r\n0\r\nx");
    start_response();
    send_string("HTTP 200\r\nTransfer-Encoding: chunked\r\n\r\n2\r\nabX");
    start_response();
    send_string("HTTP 200\r\nTransfer-Encoding: chunked\r\n\r\n123456789\r\n");
    start_response();
    send_string("HTTP 200\r\nTransfer-Encoding: chunked\r\n\r\n1;aaaaaaaaaaaaaaaaaaaaaaaaaaaaaa");
    start_response();
    send_string("HTTP 200\r\nTransfer-Encoding: chunked\r\n\r\n;\r\n");
  endtask

  task automatic send_random_response();
    int    kind;
    string hdr;
    string v;
    kind = $urandom_range(9);
    start_response();
    if (kind == 0) begin
      send_random_bytes($urandom_range(1, 40));
      return;
    end
    hdr = ($urandom_range(7) == 0) ? "HTTP 301" : "HTTP/1.1 200 OK";
    send_string(hdr);
    send_string("\r\nHost: x\r\n");
    if (kind <= 5) begin
      v.itoa($urandom_range(0, 12));
      send_string($urandom_range(1) ? "Content-Length: " : "CONTENT-length:");
      send_string(v);
      send_string("\r\n\r\n");
      send_random_bytes($urandom_range(0, 14));
    end else begin
      send_string($urandom_range(1) ? "Transfer-Encoding: chunked" : "transfer-encoding:CHUNKED");
      send_string("\r\n\r\n");
      repeat ($urandom_range(1, 3)) begin
        int n;
        n = $urandom_range(1, 9);
        v.hextoa(n);
        send_string(v);
        if ($urandom_range(3) == 0) send_string(";q");
        send_string("\r\n");
        send_random_bytes(n);
        if ($urandom_range(9) == 0) send_random_bytes(2);
        else send_string("\r\n");
      end
      send_string("0\r\n");
      send_random_bytes($urandom_range(0, 2));
    end
  endtask

  task automatic test_random(int n_items);
    int target;
    target = items_sent + n_items;
    while (items_sent < target) send_random_response();
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_off = 1;
        repeat (60) @(posedge clk);
        hold_off = 0;
      end
      send_random_response();
    join
  endtask

  initial begin
    rst <= 1;
    push <= 0;
    in_item <= '0;
    mismatches = 0;
    cycles = 0;
    items_sent = 0;
    hold_off = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    clear_parser();
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_length_body();
    test_header_errors();
    test_chunked();
    send_idle_pct = 14; recv_idle_pct = 63;
    test_random(160);
    test_backpressure();
    send_idle_pct = 63; recv_idle_pct = 14;
    test_random(160);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(160);
    push <= 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end
endmodule

/* filelist.f */
rtl/hrbd_pkg.sv
rtl/hrbd_fifo.sv
rtl/hrbd_front.sv
rtl/hrbd_back.sv
rtl/http_response_body_deframer_top.sv
tb/testbench.sv
